### rtl/dmft_pkg.sv
// Shared types, codes and constants of the DALI master frame transceiver.
`timescale 1ns / 1ps
`default_nettype none
package dmft_pkg;

  // Request opcodes on the op field
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SEND = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [7:0] BROADCAST_ADDR = 8'hFF;
  localparam int         FRAME_BITS     = 17;
  localparam int         REPLY_BITS     = 9;
  // Stop time is four half bits: shift the half-bit length left by two
  localparam int         STOP_SHIFT     = 2;

  localparam logic [9:0]  HALF_BIT_RESET    = 10'd2;
  localparam logic [9:0]  QUARTER_BIT_RESET = 10'd1;
  localparam logic [15:0] REPLY_WAIT_RESET  = 16'd80;

  // Configuration register indexes
  localparam logic [1:0] REG_HALF_BIT    = 2'd0;
  localparam logic [1:0] REG_QUARTER_BIT = 2'd1;
  localparam logic [1:0] REG_REPLY_WAIT  = 2'd2;

  localparam int CMD_QUEUE_DEPTH = 2;
  localparam int RES_QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_SEND = 2'd1,
    KIND_READ = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_SEND   = 5'b00010,
    PH_STOP   = 5'b00100,
    PH_WAIT   = 5'b01000,
    PH_SAMPLE = 5'b10000
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [16:0] frame;
    logic        rx_level;
  } cmd_t;

  typedef struct packed {
    logic [9:0]  half_bit_ticks;
    logic [9:0]  quarter_bit_ticks;
    logic [15:0] reply_wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic       tx_level;
    logic       busy_res;
    logic [7:0] reply_data;
    logic       reply_valid;
    logic       reply_timed_out;
  } res_t;

endpackage
`default_nettype wire

### rtl/dmft_fifo.sv
// Small register queue with registered count, used for the request and result queues.
`timescale 1ns / 1ps
`default_nettype none
module dmft_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rd_data = mem[rd_ptr];

  always_comb begin
    case ({do_push, do_pop})
      2'b10:   count_next = count + CNT_W'(1);
      2'b01:   count_next = count - CNT_W'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

### rtl/dmft_front.sv
// Front stage: accept requests, classify them and build the forward frame.
`timescale 1ns / 1ps
`default_nettype none
module dmft_front #(
  parameter int QUEUE_DEPTH = dmft_pkg::CMD_QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  output logic              full,
  input  wire logic [1:0]   op,
  input  wire logic [5:0]   short_address,
  input  wire logic [7:0]   command_byte,
  input  wire logic         to_all,
  input  wire logic         rx_level,
  output dmft_pkg::cmd_t    cmd,
  output logic              cmd_empty,
  input  wire logic         cmd_pop
);

  dmft_pkg::cmd_t cmd_in;
  logic [7:0]     addr_byte;

  // Short address goes out with the selector bit set
  assign addr_byte = to_all ? dmft_pkg::BROADCAST_ADDR : {1'b0, short_address, 1'b1};

  always_comb begin
    unique case (op)
      dmft_pkg::OP_TICK: cmd_in.kind = dmft_pkg::KIND_TICK;
      dmft_pkg::OP_SEND: cmd_in.kind = dmft_pkg::KIND_SEND;
      dmft_pkg::OP_READ: cmd_in.kind = dmft_pkg::KIND_READ;
      default:           cmd_in.kind = dmft_pkg::KIND_NONE;
    endcase
    cmd_in.frame    = {1'b1, addr_byte, command_byte};
    cmd_in.rx_level = rx_level;
  end

  dmft_fifo #(
    .WIDTH($bits(dmft_pkg::cmd_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data(cmd_in),
    .full   (full),
    .pop    (cmd_pop),
    .rd_data(cmd),
    .empty  (cmd_empty)
  );

endmodule
`default_nettype wire

### rtl/dmft_back.sv
// Back stage: line engine state machine and result queue.
`timescale 1ns / 1ps
`default_nettype none
module dmft_back #(
  parameter int QUEUE_DEPTH = dmft_pkg::RES_QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire dmft_pkg::cfg_t cfg,
  input  wire dmft_pkg::cmd_t cmd,
  input  wire logic           cmd_empty,
  output logic                cmd_pop,
  output dmft_pkg::res_t      res,
  output logic                res_empty,
  input  wire logic           res_pop
);

  dmft_pkg::phase_t phase, phase_next;
  logic [16:0]      tx_shift, tx_shift_next;
  logic [4:0]       bit_count, bit_count_next;
  logic [1:0]       sub_phase, sub_phase_next;
  logic [15:0]      tick_count, tick_count_next;
  logic [7:0]       rx_shift, rx_shift_next;
  logic             line_out, line_out_next;
  logic             timed_out_flag, timed_out_flag_next;

  logic             res_full;
  logic             step_en;
  dmft_pkg::res_t   res_in;

  logic [15:0]      tick_inc;
  logic [4:0]       bit_inc;
  logic [1:0]       sub_inc;
  logic [9:0]       half_eff;
  logic [9:0]       quarter_eff;
  logic [15:0]      wait_eff;
  logic [11:0]      stop_lim;

  // Advance one item whenever there is one and room for its result
  assign step_en = ~cmd_empty & ~res_full;
  assign cmd_pop = step_en;

  assign tick_inc    = tick_count + 16'd1;
  assign bit_inc     = bit_count + 5'd1;
  assign sub_inc     = sub_phase + 2'd1;
  assign half_eff    = (cfg.half_bit_ticks == '0) ? 10'd1 : cfg.half_bit_ticks;
  assign quarter_eff = (cfg.quarter_bit_ticks == '0) ? 10'd1 : cfg.quarter_bit_ticks;
  assign wait_eff    = (cfg.reply_wait_ticks == '0) ? 16'd1 : cfg.reply_wait_ticks;
  assign stop_lim    = {half_eff, 2'b00} >> (2 - dmft_pkg::STOP_SHIFT);

  always_comb begin
    phase_next          = phase;
    tx_shift_next       = tx_shift;
    bit_count_next      = bit_count;
    sub_phase_next      = sub_phase;
    tick_count_next     = tick_count;
    rx_shift_next       = rx_shift;
    line_out_next       = line_out;
    timed_out_flag_next = timed_out_flag;
    res_in.reply_data      = 8'd0;
    res_in.reply_valid     = 1'b0;
    res_in.reply_timed_out = 1'b0;

    case (cmd.kind)
      dmft_pkg::KIND_SEND: begin
        if (phase == dmft_pkg::PH_IDLE) begin
          tx_shift_next   = cmd.frame;
          phase_next      = dmft_pkg::PH_SEND;
          bit_count_next  = 5'd0;
          sub_phase_next  = 2'd0;
          tick_count_next = 16'd0;
          line_out_next   = ~cmd.frame[16];
        end
      end
      dmft_pkg::KIND_READ: begin
        if (phase == dmft_pkg::PH_IDLE) begin
          phase_next          = dmft_pkg::PH_WAIT;
          tick_count_next     = 16'd0;
          timed_out_flag_next = 1'b0;
        end
      end
      dmft_pkg::KIND_TICK: begin
        unique case (phase)
          dmft_pkg::PH_SEND: begin
            tick_count_next = tick_inc;
            if (tick_inc >= {6'd0, half_eff}) begin
              tick_count_next = 16'd0;
              if (sub_phase == 2'd0) begin
                sub_phase_next = 2'd1;
                line_out_next  = tx_shift[16];
              end else begin
                sub_phase_next = 2'd0;
                bit_count_next = bit_inc;
                tx_shift_next  = {tx_shift[15:0], 1'b0};
                if (bit_inc >= 5'(dmft_pkg::FRAME_BITS)) begin
                  phase_next    = dmft_pkg::PH_STOP;
                  line_out_next = 1'b1;
                end else begin
                  line_out_next = ~tx_shift[15];
                end
              end
            end
          end
          dmft_pkg::PH_STOP: begin
            tick_count_next = tick_inc;
            if (tick_inc >= {4'd0, stop_lim}) begin
              tick_count_next = 16'd0;
              bit_count_next  = 5'd0;
              phase_next      = dmft_pkg::PH_IDLE;
            end
          end
          dmft_pkg::PH_WAIT: begin
            if (!cmd.rx_level || tick_inc >= wait_eff) begin
              if (cmd.rx_level) begin
                timed_out_flag_next = 1'b1;
              end
              phase_next      = dmft_pkg::PH_SAMPLE;
              tick_count_next = 16'd0;
              sub_phase_next  = 2'd0;
              bit_count_next  = 5'd0;
              rx_shift_next   = 8'd0;
            end else begin
              tick_count_next = tick_inc;
            end
          end
          dmft_pkg::PH_SAMPLE: begin
            tick_count_next = tick_inc;
            if (tick_inc >= {6'd0, quarter_eff}) begin
              tick_count_next = 16'd0;
              sub_phase_next  = sub_inc;
              if (sub_inc == 2'd3) begin
                // Sample at three quarters; the start bit is dropped
                if (bit_count != 5'd0) begin
                  rx_shift_next = {rx_shift[6:0], cmd.rx_level};
                end
              end else if (sub_inc == 2'd0) begin
                bit_count_next = bit_inc;
                if (bit_inc >= 5'(dmft_pkg::REPLY_BITS)) begin
                  res_in.reply_valid     = 1'b1;
                  res_in.reply_data      = rx_shift;
                  res_in.reply_timed_out = timed_out_flag;
                  bit_count_next         = 5'd0;
                  phase_next             = dmft_pkg::PH_IDLE;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    res_in.tx_level = line_out_next;
    res_in.busy_res = (phase_next != dmft_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= dmft_pkg::PH_IDLE;
      tx_shift       <= '0;
      bit_count      <= '0;
      sub_phase      <= '0;
      tick_count     <= '0;
      rx_shift       <= '0;
      line_out       <= 1'b1;
      timed_out_flag <= 1'b0;
    end else if (step_en) begin
      phase          <= phase_next;
      tx_shift       <= tx_shift_next;
      bit_count      <= bit_count_next;
      sub_phase      <= sub_phase_next;
      tick_count     <= tick_count_next;
      rx_shift       <= rx_shift_next;
      line_out       <= line_out_next;
      timed_out_flag <= timed_out_flag_next;
    end
  end

  dmft_fifo #(
    .WIDTH($bits(dmft_pkg::res_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (step_en),
    .wr_data(res_in),
    .full   (res_full),
    .pop    (res_pop),
    .rd_data(res),
    .empty  (res_empty)
  );

endmodule
`default_nettype wire

### rtl/dali_master_frame_transceiver_unit.sv
// Top level of the DALI master frame transceiver: config registers and stages.
//
// Usage: requests enter through push/full, one transaction per cycle while
// full is low. op selects a tick, a forward frame send or a backward frame
// read; short_address, command_byte and to_all shape the forward frame and
// rx_level carries the receive line sample for ticks. Every request makes
// exactly one result, read through empty/pop in request order: the transmit
// level after the request, the busy flag and, on the tick that ends a
// backward frame, the received byte with its valid and timeout flags.
// Flow: an accepted request is registered in the request queue; the back
// stage pops it when the result queue has room and registers its result in
// the result queue, from which it is popped. Throughput is one request per
// cycle while the result queue has room, set by the line engine update.
// Timing registers are written through cfg_we/cfg_index/cfg_data, by the user
// only while no request is in flight (unenforced); a zero value counts as one.
// Reset (synchronous, rst high) empties both queues, returns the engine to
// idle with the line high and loads the default timing values.
// When the result side stalls, the result queue fills, the back stage holds,
// the request queue fills and full rises; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none
module dali_master_frame_transceiver_unit #(
  parameter int CMD_DEPTH = dmft_pkg::CMD_QUEUE_DEPTH,
  parameter int RES_DEPTH = dmft_pkg::RES_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  op,
  input  wire logic [5:0]  short_address,
  input  wire logic [7:0]  command_byte,
  input  wire logic        to_all,
  input  wire logic        rx_level,
  // result channel
  output logic             empty,
  input  wire logic        pop,
  output logic             tx_level,
  output logic             busy_res,
  output logic [7:0]       reply_data,
  output logic             reply_valid,
  output logic             reply_timed_out,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  dmft_pkg::cfg_t cfg;
  dmft_pkg::cmd_t cmd;
  dmft_pkg::res_t res;
  logic           cmd_empty;
  logic           cmd_pop;

  // Timing registers; an index past the last register is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_bit_ticks    <= dmft_pkg::HALF_BIT_RESET;
      cfg.quarter_bit_ticks <= dmft_pkg::QUARTER_BIT_RESET;
      cfg.reply_wait_ticks  <= dmft_pkg::REPLY_WAIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dmft_pkg::REG_HALF_BIT:    cfg.half_bit_ticks    <= cfg_data[9:0];
        dmft_pkg::REG_QUARTER_BIT: cfg.quarter_bit_ticks <= cfg_data[9:0];
        dmft_pkg::REG_REPLY_WAIT:  cfg.reply_wait_ticks  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Classify requests and queue them for the line engine
  dmft_front #(
    .QUEUE_DEPTH(CMD_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .op           (op),
    .short_address(short_address),
    .command_byte (command_byte),
    .to_all       (to_all),
    .rx_level     (rx_level),
    .cmd          (cmd),
    .cmd_empty    (cmd_empty),
    .cmd_pop      (cmd_pop)
  );

  // Run the line engine and hold its results until popped
  dmft_back #(
    .QUEUE_DEPTH(RES_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .res      (res),
    .res_empty(empty),
    .res_pop  (pop)
  );

  assign tx_level        = res.tx_level;
  assign busy_res        = res.busy_res;
  assign reply_data      = res.reply_data;
  assign reply_valid     = res.reply_valid;
  assign reply_timed_out = res.reply_timed_out;

endmodule
`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for the DALI master frame transceiver unit.
`timescale 1ns / 1ps
module testbench;
  import dmft_pkg::*;

  // Opcode three has no meaning; the engine must drop it like a busy request.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Register index three is not mapped; writes to it must change nothing.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // While the engine waits for a reply start, hold the receive line high this
  // often (percent), so that short waits time out and long ones see a start.
  localparam int RX_HIGH_IN_WAIT_PCT = 93;
  // Receiver hold-off used to fill both queues and raise full.
  localparam int HOLD_OFF_CYCLES = 400;
  // Longest legal stretch without a transaction is the hold-off above; allow
  // a wide margin on top of it.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS = 30;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] short_address;
    logic [7:0] command_byte;
    logic       to_all;
    logic       rx_level;
  } line_req_t;

  // DUT ports; every input holds a known value from time zero.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  op = OP_TICK;
  logic [5:0]  short_address = '0;
  logic [7:0]  command_byte = '0;
  logic        to_all = 1'b0;
  logic        rx_level = 1'b1;
  logic        empty;
  logic        pop = 1'b0;
  logic        tx_level;
  logic        busy_res;
  logic [7:0]  reply_data;
  logic        reply_valid;
  logic        reply_timed_out;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_HALF_BIT;
  logic [15:0] cfg_data = '0;

  // Line engine shadow: timing registers and engine state.
  logic [9:0]  half_ticks;
  logic [9:0]  quarter_ticks;
  logic [15:0] wait_ticks;
  phase_t      line_phase;
  logic [16:0] frame_bits;
  logic [4:0]  bit_index;
  logic [1:0]  half_step;
  logic [15:0] tick_cnt;
  logic [7:0]  reply_shift;
  logic        line_level;
  logic        wait_expired;
  logic        request_ignored;

  // Results still owed by the DUT, oldest first.
  res_t line_results_due[$];

  int send_gap_pct = 0;
  int pop_stall_pct = 0;
  int hold_off_asked = 0;
  int error_count = 0;
  int items_sent = 0;
  int frames_started = 0;
  int replies_done = 0;
  int reply_timeouts = 0;
  int settings_used = 1;
  int quiet_cycles = 0;

  dali_master_frame_transceiver_unit u_top (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .op              (op),
    .short_address   (short_address),
    .command_byte    (command_byte),
    .to_all          (to_all),
    .rx_level        (rx_level),
    .empty           (empty),
    .pop             (pop),
    .tx_level        (tx_level),
    .busy_res        (busy_res),
    .reply_data      (reply_data),
    .reply_valid     (reply_valid),
    .reply_timed_out (reply_timed_out),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Line engine prediction
  // ---------------------------------------------------------------------------

  // A zero timing register counts as one.
  function automatic int unsigned floor_one(input int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic void clear_line_model();
    half_ticks    = HALF_BIT_RESET;
    quarter_ticks = QUARTER_BIT_RESET;
    wait_ticks    = REPLY_WAIT_RESET;
    line_phase    = PH_IDLE;
    frame_bits    = '0;
    bit_index     = '0;
    half_step     = '0;
    tick_cnt      = '0;
    reply_shift   = '0;
    line_level    = 1'b1;
    wait_expired  = 1'b0;
  endfunction

  function automatic void open_sampling();
    line_phase  = PH_SAMPLE;
    tick_cnt    = '0;
    half_step   = '0;
    bit_index   = '0;
    reply_shift = '0;
  endfunction

  // Apply one request to the shadow engine and return the result it owes.
  function automatic res_t advance_line(input line_req_t r);
    res_t       res;
    logic [7:0] addr_byte;
    res = '0;
    request_ignored = 1'b1;
    case (r.op)
      OP_SEND: begin
        if (line_phase == PH_IDLE) begin
          addr_byte = r.to_all ? BROADCAST_ADDR : {1'b0, r.short_address, 1'b1};
          frame_bits = {1'b1, addr_byte, r.command_byte};
          line_phase = PH_SEND;
          bit_index  = '0;
          half_step  = '0;
          tick_cnt   = '0;
          line_level = ~frame_bits[16];
          request_ignored = 1'b0;
          frames_started++;
        end
      end
      OP_READ: begin
        if (line_phase == PH_IDLE) begin
          line_phase   = PH_WAIT;
          tick_cnt     = '0;
          wait_expired = 1'b0;
          request_ignored = 1'b0;
        end
      end
      OP_TICK: begin
        request_ignored = (line_phase == PH_IDLE);
        case (line_phase)
          PH_SEND: begin
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= floor_one(half_ticks)) begin
              tick_cnt = '0;
              if (half_step == 2'd0) begin
                // second half of a Manchester bit carries the bit value
                half_step  = 2'd1;
                line_level = frame_bits[16];
              end else begin
                half_step  = 2'd0;
                bit_index  = bit_index + 5'd1;
                frame_bits = frame_bits << 1;
                if (bit_index >= FRAME_BITS) begin
                  line_phase = PH_STOP;
                  line_level = 1'b1;
                end else begin
                  line_level = ~frame_bits[16];
                end
              end
            end
          end
          PH_STOP: begin
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= (floor_one(half_ticks) << STOP_SHIFT)) begin
              tick_cnt   = '0;
              bit_index  = '0;
              line_phase = PH_IDLE;
            end
          end
          PH_WAIT: begin
            if (!r.rx_level) begin
              open_sampling();
            end else begin
              tick_cnt = tick_cnt + 16'd1;
              if (tick_cnt >= floor_one(wait_ticks)) begin
                wait_expired = 1'b1;
                open_sampling();
              end
            end
          end
          PH_SAMPLE: begin
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= floor_one(quarter_ticks)) begin
              tick_cnt  = '0;
              half_step = half_step + 2'd1;
              if (half_step == 2'd3) begin
                // three-quarter point; the start bit is not stored
                if (bit_index != 0) reply_shift = {reply_shift[6:0], r.rx_level};
              end else if (half_step == 2'd0) begin
                bit_index = bit_index + 5'd1;
                if (bit_index >= REPLY_BITS) begin
                  res.reply_valid     = 1'b1;
                  res.reply_data      = reply_shift;
                  res.reply_timed_out = wait_expired;
                  bit_index  = '0;
                  line_phase = PH_IDLE;
                  replies_done++;
                  if (wait_expired) reply_timeouts++;
                end
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    res.tx_level = line_level;
    res.busy_res = (line_phase != PH_IDLE);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic line_req_t make_request(input logic [1:0] kind, input logic [5:0] addr,
                                             input logic [7:0] cmd, input logic bcast,
                                             input logic rx);
    line_req_t r;
    r.op            = kind;
    r.short_address = addr;
    r.command_byte  = cmd;
    r.to_all        = bcast;
    r.rx_level      = rx;
    return r;
  endfunction

  // Mostly well-formed traffic: start a frame or a read when idle, tick it to
  // completion when busy, with some busy requests and dead opcodes mixed in.
  function automatic line_req_t draw_request();
    line_req_t r;
    int        roll;
    r.short_address = 6'($urandom_range(0, 63));
    r.command_byte  = 8'($urandom_range(0, 255));
    r.to_all        = ($urandom_range(0, 3) == 0);
    r.rx_level      = 1'($urandom_range(0, 1));
    roll = $urandom_range(0, 99);
    if (line_phase == PH_IDLE) begin
      if (roll < 40)      r.op = OP_SEND;
      else if (roll < 80) r.op = OP_READ;
      else if (roll < 90) r.op = OP_TICK;
      else                r.op = OP_UNUSED;
    end else begin
      if (roll < 90)      r.op = OP_TICK;
      else if (roll < 94) r.op = OP_SEND;
      else if (roll < 97) r.op = OP_READ;
      else                r.op = OP_UNUSED;
      if (line_phase == PH_WAIT) r.rx_level = ($urandom_range(0, 99) < RX_HIGH_IN_WAIT_PCT);
    end
    return r;
  endfunction

  function automatic void set_idling(input int gap_pct, input int stall_pct);
    send_gap_pct  = gap_pct;
    pop_stall_pct = stall_pct;
  endfunction

  // Offer one transaction and wait until the DUT takes it. Push is left high
  // on return; the next call or the drain decides what it does next.
  task automatic send_request(input line_req_t r);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push          <= 1'b1;
    op            <= r.op;
    short_address <= r.short_address;
    command_byte  <= r.command_byte;
    to_all        <= r.to_all;
    rx_level      <= r.rx_level;
    do @(posedge clk); while (full);
    line_results_due.push_back(advance_line(r));
    items_sent++;
  endtask

  // Send random traffic until n transactions have had an effect on the engine.
  task automatic run_random(input int n);
    int useful;
    useful = 0;
    while (useful < n) begin
      send_request(draw_request());
      if (!request_ignored) useful++;
    end
  endtask

  // Tick the engine until the current frame or reply is complete.
  task automatic run_until_idle();
    line_req_t r;
    while (line_phase != PH_IDLE) begin
      r = draw_request();
      r.op = OP_TICK;
      send_request(r);
    end
  endtask

  // Stop offering and hold until every owed result is back.
  task automatic wait_results_in();
    push <= 1'b0;
    while (line_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Program all timing registers, then poke the unmapped index. Junk in the
  // upper bits of the 10-bit registers must be dropped.
  task automatic load_timing(input logic [9:0] half, input logic [9:0] quarter,
                             input logic [15:0] wait_len);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HALF_BIT;
    cfg_data  <= {6'($urandom_range(0, 63)), half};
    @(posedge clk);
    cfg_index <= REG_QUARTER_BIT;
    cfg_data  <= {6'($urandom_range(0, 63)), quarter};
    @(posedge clk);
    cfg_index <= REG_REPLY_WAIT;
    cfg_data  <= wait_len;
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_data  <= 16'($urandom_range(0, 65535));
    @(posedge clk);
    cfg_we <= 1'b0;
    half_ticks    = half;
    quarter_ticks = quarter;
    wait_ticks    = wait_len;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Idle ticks, dead opcode, a frame to address 63 and requests that arrive
  // while it is on the line; then a real broadcast, and a frame to address 0.
  task automatic test_directed();
    set_idling(0, 0);
    send_request(make_request(OP_TICK, 6'd0, 8'h00, 1'b0, 1'b0));
    send_request(make_request(OP_TICK, 6'd63, 8'hFF, 1'b1, 1'b1));
    send_request(make_request(OP_UNUSED, 6'd63, 8'hFF, 1'b1, 1'b1));
    send_request(make_request(OP_SEND, 6'd63, 8'h00, 1'b0, 1'b1));
    send_request(make_request(OP_SEND, 6'd0, 8'hFF, 1'b1, 1'b0));
    send_request(make_request(OP_READ, 6'd0, 8'h00, 1'b0, 1'b0));
    send_request(make_request(OP_UNUSED, 6'd21, 8'h5A, 1'b0, 1'b0));
    for (int k = 0; k < 6; k++) send_request(make_request(OP_TICK, 6'd42, 8'hA5, 1'b0, k[0]));
    run_until_idle();
    send_request(make_request(OP_SEND, 6'd0, 8'hFF, 1'b1, 1'b0));
    send_request(make_request(OP_READ, 6'd1, 8'h01, 1'b0, 1'b1));
    run_until_idle();
    send_request(make_request(OP_SEND, 6'd0, 8'h00, 1'b0, 1'b0));
    run_until_idle();
    wait_results_in();
  endtask

  // Same traffic under each idling pattern at the reset timing.
  task automatic test_idling_modes();
    set_idling(0, 0);
    run_random(150);
    set_idling(71, 0);
    run_random(150);
    set_idling(0, 71);
    run_random(150);
    set_idling(31, 31);
    run_random(150);
    run_until_idle();
    wait_results_in();
  endtask

  // Minimum, zero (counts as one), fixed and random small timing values.
  task automatic test_timing_settings();
    for (int k = 0; k < 6; k++) begin
      case (k)
        0:       load_timing(10'd1, 10'd1, 16'd1);
        1:       load_timing(10'd0, 10'd0, 16'd0);
        2:       load_timing(10'd3, 10'd2, 16'd20);
        default: load_timing(10'($urandom_range(1, 6)), 10'($urandom_range(1, 4)),
                             16'($urandom_range(1, 40)));
      endcase
      if (k == 0) set_idling(0, 0);
      else        set_idling(31, 31);
      run_random(40);
      run_until_idle();
      wait_results_in();
    end
  endtask

  // Hold off the result side while requests keep coming, so that both queues
  // fill and full rises; then let it drain completely.
  task automatic test_backpressure();
    set_idling(0, 0);
    hold_off_asked++;
    run_random(60);
    run_until_idle();
    wait_results_in();
  endtask

  // Largest reply wait (the start arrives well before it), with slower half
  // and quarter bits: one whole frame and one whole reply.
  task automatic test_longest_timing();
    load_timing(10'd5, 10'd3, 16'hFFFF);
    set_idling(0, 0);
    send_request(make_request(OP_SEND, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                              1'b0, 1'b1));
    run_until_idle();
    send_request(make_request(OP_READ, 6'd0, 8'h00, 1'b0, 1'b1));
    run_until_idle();
    wait_results_in();
  endtask

  initial begin
    clear_line_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_idling_modes();
    test_timing_settings();
    test_backpressure();
    test_longest_timing();
    // trailing settle time for anything the DUT might still emit
    repeat (8) @(posedge clk);
    $display("Covered %0d transactions over %0d timing settings: %0d forward frames,",
             items_sent, settings_used, frames_started);
    $display("  %0d backward frames (%0d timed out), four idling patterns, one long hold-off",
             replies_done, reply_timeouts);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random pops, hold-off, field-by-field compare
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  initial begin : result_checker
    res_t want;
    int   hold_left;
    int   holds_taken;
    hold_left   = 0;
    holds_taken = 0;
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        if (line_results_due.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t ns: result with no transaction outstanding, expected none, got %0h",
                     $time, {tx_level, busy_res, reply_data, reply_valid, reply_timed_out});
        end else begin
          want = line_results_due.pop_front();
          check_field("tx_level", 8'(want.tx_level), 8'(tx_level));
          check_field("busy_res", 8'(want.busy_res), 8'(busy_res));
          check_field("reply_data", want.reply_data, reply_data);
          check_field("reply_valid", 8'(want.reply_valid), 8'(reply_valid));
          check_field("reply_timed_out", 8'(want.reply_timed_out), 8'(reply_timed_out));
        end
      end
      // start a hold-off when one is asked for, and count it down here
      if (holds_taken != hold_off_asked) begin
        holds_taken = hold_off_asked;
        hold_left   = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= !rst && ($urandom_range(0, 99) >= pop_stall_pct);
      end
    end
  end

  // Abort when no transaction moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: %0d cycles without a transaction", quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule
